// ===== rtl/box_downsample_to_rgb8_unit_macros.svh =====
// Assertion helpers shared by the block. Both expect signals named clk and rst_n
// in the module where they are used.
`ifndef BOX_DOWNSAMPLE_TO_RGB8_UNIT_MACROS_SVH
`define BOX_DOWNSAMPLE_TO_RGB8_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdr_pkg.sv =====
package bdr_pkg;

  localparam int unsigned NCH          = 3;
  localparam int unsigned PIX_W        = 16;
  localparam int unsigned SUM_W        = 22;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CSQ_W        = 8;
  localparam int unsigned PROD_W       = SUM_W + GAIN_W;
  localparam int unsigned X_W          = PROD_W + 8;
  localparam int unsigned Y_W          = X_W + 1;
  localparam int unsigned HALF_SHIFT   = 19;
  localparam int unsigned DROP_SHIFT   = 20;
  localparam int unsigned YH_W         = Y_W - DROP_SHIFT;
  localparam int unsigned Q_W          = 8;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned RADIUS_REG_W = 2;

  localparam logic [BYTE_W-1:0]       BYTE_MAX      = 8'd255;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST     = 11'd640;
  localparam logic [RADIUS_REG_W-1:0] RADIUS_RST    = 2'd1;
  localparam logic [GAIN_W-1:0]       GAIN_RST      = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_WIDTH    = 2'd0,
    REG_BLOCK_RADIUS = 2'd1,
    REG_GAIN         = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             frame_start;
  } bdr_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
    logic              row_end;
  } bdr_out_t;

  typedef struct packed {
    logic valid;
    logic row_end;
  } bdr_tag_t;

  typedef logic [NCH-1:0][SUM_W-1:0] bdr_sums_t;
  typedef logic [NCH-1:0][PIX_W-1:0] bdr_pix_t;

endpackage

// ===== rtl/bdr_ram.sv =====
module bdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bdr_scale.sv =====
module bdr_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  bdr_pkg::bdr_tag_t             in_tag,
  input  bdr_pkg::bdr_sums_t            in_sums,
  input  logic [bdr_pkg::GAIN_W-1:0]    gain,
  input  logic [bdr_pkg::CSQ_W-1:0]     c_sq,
  output bdr_pkg::bdr_tag_t             out_tag,
  output bdr_pkg::bdr_out_t             out_data
);

  localparam int unsigned NCH   = bdr_pkg::NCH;
  localparam int unsigned STEPS = bdr_pkg::Q_W;

  // Stage 1: block sum times gain.
  bdr_pkg::bdr_tag_t              tag1_r;
  logic [bdr_pkg::PROD_W-1:0]     prod1_r [NCH];
  logic [bdr_pkg::PROD_W-1:0]     prod1_nxt [NCH];

  // Division pipeline: entry 0 holds the rounded, pre-shifted value, each later
  // entry has resolved one more quotient bit, most significant first.
  bdr_pkg::bdr_tag_t              tag_r [STEPS+1];
  logic [bdr_pkg::YH_W-1:0]       rem_r [STEPS+1][NCH];
  logic [bdr_pkg::YH_W-1:0]       rem_nxt [STEPS+1][NCH];
  logic [bdr_pkg::Q_W-1:0]        q_r [STEPS+1][NCH];
  logic [bdr_pkg::Q_W-1:0]        q_nxt [STEPS+1][NCH];
  logic                           sat_r [STEPS+1][NCH];
  logic                           sat_nxt [STEPS+1][NCH];
  logic [bdr_pkg::YH_W-1:0]       dvs [STEPS];

  logic [bdr_pkg::X_W-1:0]        x2 [NCH];
  logic [bdr_pkg::Y_W-1:0]        y2 [NCH];
  logic [bdr_pkg::YH_W-1:0]       sat_lim;

  bdr_pkg::bdr_tag_t              out_tag_r;
  bdr_pkg::bdr_out_t              out_r;
  bdr_pkg::bdr_out_t              out_nxt;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      prod1_nxt[ch] = bdr_pkg::PROD_W'(in_sums[ch]) * bdr_pkg::PROD_W'(gain);
    end
  end

  // Times 255 as a shift and subtract, then add half a divisor and drop the 20
  // fraction bits, which the divisor c*c*2^20 has as zeros anyway.
  always_comb begin
    sat_lim = {{(bdr_pkg::YH_W - bdr_pkg::CSQ_W - bdr_pkg::Q_W){1'b0}}, c_sq,
               {bdr_pkg::Q_W{1'b0}}};
    for (int ch = 0; ch < NCH; ch++) begin
      x2[ch] = {prod1_r[ch], 8'd0} - {8'd0, prod1_r[ch]};
      y2[ch] = {1'b0, x2[ch]} +
               {{(bdr_pkg::Y_W - bdr_pkg::CSQ_W - bdr_pkg::HALF_SHIFT){1'b0}}, c_sq,
                {bdr_pkg::HALF_SHIFT{1'b0}}};
      rem_nxt[0][ch] = y2[ch][bdr_pkg::Y_W-1:bdr_pkg::DROP_SHIFT];
      q_nxt[0][ch]   = '0;
      sat_nxt[0][ch] = (rem_nxt[0][ch] >= sat_lim);
    end
    for (int k = 0; k < STEPS; k++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        sat_nxt[k+1][ch] = sat_r[k][ch];
        if (rem_r[k][ch] >= dvs[k]) begin
          rem_nxt[k+1][ch] = rem_r[k][ch] - dvs[k];
          q_nxt[k+1][ch]   = q_r[k][ch] | (bdr_pkg::Q_W'(1) << (STEPS - 1 - k));
        end else begin
          rem_nxt[k+1][ch] = rem_r[k][ch];
          q_nxt[k+1][ch]   = q_r[k][ch];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      dvs[k] = bdr_pkg::YH_W'(c_sq) << (STEPS - 1 - k);
    end
  end

  always_comb begin
    out_nxt.red_out   = sat_r[STEPS][0] ? bdr_pkg::BYTE_MAX : q_r[STEPS][0];
    out_nxt.green_out = sat_r[STEPS][1] ? bdr_pkg::BYTE_MAX : q_r[STEPS][1];
    out_nxt.blue_out  = sat_r[STEPS][2] ? bdr_pkg::BYTE_MAX : q_r[STEPS][2];
    out_nxt.row_end   = tag_r[STEPS].row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid    <= 1'b0;
      out_tag_r.valid <= 1'b0;
      for (int k = 0; k <= STEPS; k++) begin
        tag_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      tag1_r    <= in_tag;
      tag_r[0]  <= tag1_r;
      for (int k = 0; k < STEPS; k++) begin
        tag_r[k+1] <= tag_r[k];
      end
      out_tag_r <= tag_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < NCH; ch++) begin
        prod1_r[ch] <= prod1_nxt[ch];
      end
      for (int k = 0; k <= STEPS; k++) begin
        for (int ch = 0; ch < NCH; ch++) begin
          rem_r[k][ch] <= rem_nxt[k][ch];
          q_r[k][ch]   <= q_nxt[k][ch];
          sat_r[k][ch] <= sat_nxt[k][ch];
        end
      end
      out_r <= out_nxt;
    end
  end

  assign out_tag  = out_tag_r;
  assign out_data = out_r;

endmodule

// ===== rtl/box_downsample_to_rgb8_unit.sv =====
// Box-filter downscaler: takes one RGB supersample per clock in raster order and
// sums each (2r+1) by (2r+1) block per channel in a line of column sums held in a
// single RAM (MAX_WIDTH words of three 22-bit sums, registered read; no
// clearing pass is needed, since the first sub-row of a band overwrites). Every
// supersample is read in the cycle it is taken and written back once the pipeline
// advances; back-to-back hits on the same column are forwarded from a register. A
// finished block then goes through 11 pipeline registers (gain multiply, times 255
// with rounding, an 8-step restoring divide by c*c with one quotient bit per stage,
// and the output register) before its result word is valid. Sustained rate is one
// supersample per clock; in_ready falls only while a result word waits on
// out_ready, which stalls the whole pipeline. Registers may be rewritten only
// while the block is idle.
`include "box_downsample_to_rgb8_unit_macros.svh"

module box_downsample_to_rgb8_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_RADIUS = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bdr_pkg::bdr_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bdr_pkg::bdr_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [bdr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [bdr_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned SUB_W = $clog2(2 * MAX_RADIUS + 1);
  localparam int unsigned EXT_W = (COL_W + 1 > bdr_pkg::WIDTH_REG_W) ?
                                  COL_W + 1 : bdr_pkg::WIDTH_REG_W;
  localparam int unsigned RAM_W = bdr_pkg::NCH * bdr_pkg::SUM_W;

  // Configuration registers.
  logic [bdr_pkg::WIDTH_REG_W-1:0]  out_width_r;
  logic [bdr_pkg::RADIUS_REG_W-1:0] block_radius_r;
  logic [bdr_pkg::GAIN_W-1:0]       gain_r;

  // Position counters.
  logic [SUB_W-1:0] sub_col_r, sub_col_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [SUB_W-1:0] sub_row_r, sub_row_nxt;

  logic [COL_W-1:0]           w_last;
  logic [SUB_W-1:0]           c_last;
  logic [bdr_pkg::CSQ_W-1:0]  c_ext;
  logic [bdr_pkg::CSQ_W-1:0]  c_sq;

  logic [SUB_W-1:0] sc0, sc, sr0, sr;
  logic [COL_W-1:0] oc0, oc;
  logic             adv, accept;

  // Read-modify-write stage.
  logic                  b_valid_r;
  logic [COL_W-1:0]      b_col_r;
  logic                  b_first_r;
  logic                  b_emit_r;
  logic                  b_row_end_r;
  bdr_pkg::bdr_pix_t     b_pix_r;
  logic                  fwd_hit_r;
  bdr_pkg::bdr_sums_t    fwd_data_r;
  bdr_pkg::bdr_sums_t    base;
  bdr_pkg::bdr_sums_t    b_sum;
  logic [RAM_W-1:0]      ram_rdata;

  bdr_pkg::bdr_tag_t     scale_tag;
  bdr_pkg::bdr_tag_t     res_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r    <= bdr_pkg::WIDTH_RST;
      block_radius_r <= bdr_pkg::RADIUS_RST;
      gain_r         <= bdr_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (bdr_pkg::cfg_reg_t'(cfg_addr))
        bdr_pkg::REG_OUT_WIDTH:    out_width_r    <= cfg_wdata[bdr_pkg::WIDTH_REG_W-1:0];
        bdr_pkg::REG_BLOCK_RADIUS: block_radius_r <= cfg_wdata[bdr_pkg::RADIUS_REG_W-1:0];
        bdr_pkg::REG_GAIN:         gain_r         <= cfg_wdata[bdr_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective width and block side after the zero and saturation rules.
  always_comb begin
    if (out_width_r == '0) begin
      w_last = '0;
    end else if (EXT_W'(out_width_r) > EXT_W'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(out_width_r - 1'b1);
    end
    if (32'(block_radius_r) > MAX_RADIUS) begin
      c_last = SUB_W'(2 * MAX_RADIUS);
    end else begin
      c_last = SUB_W'({block_radius_r, 1'b0});
    end
    c_ext = bdr_pkg::CSQ_W'(c_last) + 1'b1;
    c_sq  = c_ext * c_ext;
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  // Position of the incoming supersample; frame_start and stale counters count as zero.
  always_comb begin
    sc0 = in_data.frame_start ? '0 : sub_col_r;
    oc0 = in_data.frame_start ? '0 : out_col_r;
    sr0 = in_data.frame_start ? '0 : sub_row_r;
    sc  = (sc0 > c_last) ? '0 : sc0;
    oc  = (oc0 > w_last) ? '0 : oc0;
    sr  = (sr0 > c_last) ? '0 : sr0;
  end

  always_comb begin
    sub_col_nxt = sc + 1'b1;
    out_col_nxt = oc;
    sub_row_nxt = sr;
    if (sc == c_last) begin
      sub_col_nxt = '0;
      if (oc == w_last) begin
        out_col_nxt = '0;
        sub_row_nxt = (sr == c_last) ? '0 : sr + 1'b1;
      end else begin
        out_col_nxt = oc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_col_r <= '0;
      out_col_r <= '0;
      sub_row_r <= '0;
    end else if (accept) begin
      sub_col_r <= sub_col_nxt;
      out_col_r <= out_col_nxt;
      sub_row_r <= sub_row_nxt;
    end
  end

  // The RAM returns the old word when the previous supersample writes the same
  // column in the cycle of the read, so that write is forwarded instead.
  always_comb begin
    base = fwd_hit_r ? fwd_data_r : bdr_pkg::bdr_sums_t'(ram_rdata);
    for (int ch = 0; ch < bdr_pkg::NCH; ch++) begin
      b_sum[ch] = (b_first_r ? '0 : base[ch]) + bdr_pkg::SUM_W'(b_pix_r[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= accept;
      fwd_hit_r <= accept && b_valid_r && (b_col_r == oc);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col_r     <= oc;
      b_first_r   <= (sr == '0) && (sc == '0);
      b_emit_r    <= (sr == c_last) && (sc == c_last);
      b_row_end_r <= (oc == w_last);
      b_pix_r     <= {in_data.blue_in, in_data.green_in, in_data.red_in};
      fwd_data_r  <= b_sum;
    end
  end

  bdr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums_ram (
    .clk   (clk),
    .we    (b_valid_r && adv),
    .waddr (b_col_r),
    .wdata (RAM_W'(b_sum)),
    .re    (accept),
    .raddr (oc),
    .rdata (ram_rdata)
  );

  assign scale_tag.valid   = b_valid_r && b_emit_r;
  assign scale_tag.row_end = b_row_end_r;

  bdr_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_tag   (scale_tag),
    .in_sums  (b_sum),
    .gain     (gain_r),
    .c_sq     (c_sq),
    .out_tag  (res_tag),
    .out_data (out_data)
  );

  assign out_valid = res_tag.valid;

  `BDR_ASSERT_SAME(a_fwd_needs_item, fwd_hit_r, b_valid_r,
                   "forward flag without an item in flight")
  `BDR_ASSERT_NEXT(a_rmw_holds_on_stall, b_valid_r && !in_ready,
                   b_valid_r && $stable(b_col_r), "read-modify-write item lost during stall")
  `BDR_ASSERT_NEXT(a_frame_start_row, accept && in_data.frame_start, sub_row_r == '0,
                   "frame start did not restart the band")

endmodule
